// ===== rtl/core/hhlf_pkg.sv =====
// Shared constants, types and the key table of the HTTP header length framer.
package hhlf_pkg;

   // Width of the parsed length and of the body counter.
   localparam int LEN_BITS = 32;

   // Width of the length and count fields on the result port.
   localparam int OUT_LEN_BITS = 32;

   // Length of the key text and width of the key position.
   localparam int KEY_LEN      = 15;
   localparam int KEY_POS_BITS = 5;

   // Character codes that the parser looks for.
   localparam logic [7:0] CHAR_CR    = 8'h0d;
   localparam logic [7:0] CHAR_LF    = 8'h0a;
   localparam logic [7:0] CHAR_SPACE = 8'h20;
   localparam logic [7:0] CHAR_TAB   = 8'h09;
   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_NINE  = 8'h39;
   localparam logic [7:0] CHAR_UP_A  = 8'h41;
   localparam logic [7:0] CHAR_UP_Z  = 8'h5a;

   // Status codes shown on the result port.
   localparam logic [2:0] STATUS_HEADER    = 3'd0;
   localparam logic [2:0] STATUS_BODY      = 3'd1;
   localparam logic [2:0] STATUS_DONE_LEN  = 3'd2;
   localparam logic [2:0] STATUS_DONE_NONE = 3'd3;
   localparam logic [2:0] STATUS_CLOSED    = 3'd4;

   // One result word as it sits in the output and skid registers.
   typedef struct packed {
      logic [2:0]              status;
      logic                    is_body;
      logic                    length_known;
      logic [OUT_LEN_BITS-1:0] length_value;
      logic [OUT_LEN_BITS-1:0] body_count;
   } rsp_word_type;

   // Lower-case key text "content-length:", one character per position.
   function automatic logic [7:0] key_char(input logic [3:0] idx);
      logic [7:0] ch;
      case (idx)
         4'd0:    ch = 8'h63; // c
         4'd1:    ch = 8'h6f; // o
         4'd2:    ch = 8'h6e; // n
         4'd3:    ch = 8'h74; // t
         4'd4:    ch = 8'h65; // e
         4'd5:    ch = 8'h6e; // n
         4'd6:    ch = 8'h74; // t
         4'd7:    ch = 8'h2d; // -
         4'd8:    ch = 8'h6c; // l
         4'd9:    ch = 8'h65; // e
         4'd10:   ch = 8'h6e; // n
         4'd11:   ch = 8'h67; // g
         4'd12:   ch = 8'h74; // t
         4'd13:   ch = 8'h68; // h
         4'd14:   ch = 8'h3a; // :
         default: ch = 8'h00;
      endcase
      return ch;
   endfunction

endpackage

// ===== rtl/core/http_header_length_framer.sv =====
// Top level of the HTTP header length framer: parser state, result register and skid stage.
//
// The block takes an HTTP request one word per cycle on the req_ channel while req_stall
// is low. A word carries either one received byte (req_action 0) or a close by the peer
// (req_action 1). For every accepted word it returns exactly one result word on the rsp_
// channel: the framing status, whether the byte belongs to the body, the parsed content
// length and the count of body bytes so far.
// The parser state updates at the edge that accepts the word, and at the same edge its
// result word is registered in the result register, or in the skid register if it stalls.
// Throughput is one word per cycle while req_stall is low; it is set by the single pass of
// parser logic from the input word and the parser state into the result register.
// When the receiver stalls, a second result register (skid stage) takes one more word;
// req_stall is raised only while that skid register is full, and drops the cycle after
// the receiver takes a word.
// Reset clears the parser to the header phase with no length known, the body count to
// zero, and both result registers to empty.
module http_header_length_framer (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic                             req_action,
   input  logic [7:0]                       req_data_byte,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic [2:0]                       rsp_status,
   output logic                             rsp_is_body,
   output logic                             rsp_length_known,
   output logic [hhlf_pkg::OUT_LEN_BITS-1:0] rsp_content_length,
   output logic [hhlf_pkg::OUT_LEN_BITS-1:0] rsp_body_count
);
   import hhlf_pkg::*;

   typedef enum logic [2:0] {
      PH_HEADER    = STATUS_HEADER,
      PH_BODY      = STATUS_BODY,
      PH_DONE_LEN  = STATUS_DONE_LEN,
      PH_DONE_NONE = STATUS_DONE_NONE,
      PH_CLOSED    = STATUS_CLOSED
   } phase_type;

   typedef enum logic [1:0] {
      LM_KEY    = 2'd0,
      LM_SPACE  = 2'd1,
      LM_DIGITS = 2'd2,
      LM_SKIP   = 2'd3
   } line_mode_type;

   // Parser state.
   phase_type                phase_ff, phase_in;
   logic [1:0]               term_ff, term_in;
   logic [KEY_POS_BITS-1:0]  key_pos_ff, key_pos_in;
   line_mode_type            mode_ff, mode_in;
   logic [LEN_BITS-1:0]      acc_ff, acc_in;
   logic                     seen_ff, seen_in;
   logic                     ovf_ff, ovf_in;
   logic                     found_ff, found_in;
   logic [LEN_BITS-1:0]      stored_ff, stored_in;
   logic [LEN_BITS-1:0]      body_ff, body_in;

   // Result register and skid stage.
   logic                     out_valid_ff;
   logic                     skid_valid_ff;
   rsp_word_type             out_word_ff;
   rsp_word_type             skid_word_ff;
   rsp_word_type             word_in;

   logic                     accept;
   logic                     take;
   logic                     out_free;
   logic                     body_flag;
   logic [7:0]               lower;
   logic                     is_digit;
   logic [LEN_BITS+3:0]      acc_next;
   logic                     end_of_header;
   logic [LEN_BITS-1:0]      body_inc;

   assign accept    = req_valid && !req_stall;
   assign take      = out_valid_ff && !rsp_stall;
   assign out_free  = !out_valid_ff || take;
   assign req_stall = skid_valid_ff;

   // Lower-case the byte for the key compare, and classify digits.
   assign lower    = (req_data_byte >= CHAR_UP_A && req_data_byte <= CHAR_UP_Z) ?
                     (req_data_byte + 8'd32) : req_data_byte;
   assign is_digit = (req_data_byte >= CHAR_ZERO) && (req_data_byte <= CHAR_NINE);

   // Ten times the value plus the digit, with four guard bits to spot overflow.
   assign acc_next = ({4'b0, acc_ff} << 3) + ({4'b0, acc_ff} << 1) +
                     {{LEN_BITS{1'b0}}, req_data_byte[3:0] - CHAR_ZERO[3:0]};
   assign body_inc = body_ff + {{(LEN_BITS-1){1'b0}}, 1'b1};

   // Next parser state for the word on the input.
   always_comb begin
      phase_in      = phase_ff;
      term_in       = term_ff;
      key_pos_in    = key_pos_ff;
      mode_in       = mode_ff;
      acc_in        = acc_ff;
      seen_in       = seen_ff;
      ovf_in        = ovf_ff;
      found_in      = found_ff;
      stored_in     = stored_ff;
      body_in       = body_ff;
      body_flag     = 1'b0;
      end_of_header = 1'b0;

      if (req_action) begin
         if (phase_ff == PH_HEADER || phase_ff == PH_BODY) begin
            phase_in = PH_CLOSED;
         end
      end else if (phase_ff == PH_HEADER) begin
         // Track progress through CR LF CR LF.
         if (req_data_byte == CHAR_CR) begin
            term_in = (term_ff == 2'd2) ? 2'd3 : 2'd1;
         end else if (req_data_byte == CHAR_LF && term_ff == 2'd1) begin
            term_in = 2'd2;
         end else begin
            term_in       = 2'd0;
            end_of_header = (req_data_byte == CHAR_LF) && (term_ff == 2'd3);
         end

         if (req_data_byte == CHAR_LF && (term_ff == 2'd1 || term_ff == 2'd3)) begin
            // A line ends: start matching the key again.
            key_pos_in = '0;
            mode_in    = LM_KEY;
            acc_in     = '0;
            seen_in    = 1'b0;
            ovf_in     = 1'b0;
         end else begin
            case (mode_ff)
               LM_KEY: begin
                  if (key_pos_ff < KEY_POS_BITS'(KEY_LEN) &&
                      lower == key_char(key_pos_ff[3:0])) begin
                     key_pos_in = key_pos_ff + KEY_POS_BITS'(1);
                     if (key_pos_ff == KEY_POS_BITS'(KEY_LEN - 1)) begin
                        mode_in = found_ff ? LM_SKIP : LM_SPACE;
                     end
                  end else begin
                     mode_in = LM_SKIP;
                  end
               end
               LM_SPACE, LM_DIGITS: begin
                  if (mode_ff == LM_SPACE &&
                      (req_data_byte == CHAR_SPACE || req_data_byte == CHAR_TAB)) begin
                     mode_in = LM_SPACE;
                  end else if (is_digit) begin
                     mode_in = LM_DIGITS;
                     seen_in = 1'b1;
                     if (!ovf_ff) begin
                        if (|acc_next[LEN_BITS+3:LEN_BITS]) begin
                           ovf_in = 1'b1;
                        end else begin
                           acc_in = acc_next[LEN_BITS-1:0];
                        end
                     end
                  end else begin
                     // The value ends at the first byte that is not a digit.
                     if (seen_ff && !ovf_ff && !found_ff) begin
                        found_in  = 1'b1;
                        stored_in = acc_ff;
                     end
                     mode_in = LM_SKIP;
                  end
               end
               default: begin
                  mode_in = LM_SKIP;
               end
            endcase
         end

         if (end_of_header) begin
            if (!found_in) begin
               phase_in = PH_DONE_NONE;
            end else if (stored_in == '0) begin
               phase_in = PH_DONE_LEN;
            end else begin
               phase_in = PH_BODY;
            end
         end
      end else if (phase_ff == PH_BODY) begin
         body_flag = 1'b1;
         body_in   = body_inc;
         if (body_inc == stored_ff) begin
            phase_in = PH_DONE_LEN;
         end
      end
   end

   // Result word built from the next state.
   always_comb begin
      word_in.status         = phase_in;
      word_in.is_body        = body_flag;
      word_in.length_known   = found_in;
      word_in.length_value   = OUT_LEN_BITS'(stored_in);
      word_in.body_count     = OUT_LEN_BITS'(body_in);
   end

   // Parser state registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_HEADER;
         term_ff    <= '0;
         key_pos_ff <= '0;
         mode_ff    <= LM_KEY;
         acc_ff     <= '0;
         seen_ff    <= 1'b0;
         ovf_ff     <= 1'b0;
         found_ff   <= 1'b0;
         stored_ff  <= '0;
         body_ff    <= '0;
      end else if (accept) begin
         phase_ff   <= phase_in;
         term_ff    <= term_in;
         key_pos_ff <= key_pos_in;
         mode_ff    <= mode_in;
         acc_ff     <= acc_in;
         seen_ff    <= seen_in;
         ovf_ff     <= ovf_in;
         found_ff   <= found_in;
         stored_ff  <= stored_in;
         body_ff    <= body_in;
      end
   end

   // Result register with a skid stage behind it.
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (out_free) begin
         if (skid_valid_ff) begin
            out_valid_ff  <= 1'b1;
            skid_valid_ff <= 1'b0;
         end else begin
            out_valid_ff  <= accept;
         end
      end else if (accept) begin
         skid_valid_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (out_free) begin
         if (skid_valid_ff) begin
            out_word_ff <= skid_word_ff;
         end else if (accept) begin
            out_word_ff <= word_in;
         end
      end else if (accept) begin
         skid_word_ff <= word_in;
      end
   end

   assign rsp_valid          = out_valid_ff;
   assign rsp_status         = out_word_ff.status;
   assign rsp_is_body        = out_word_ff.is_body;
   assign rsp_length_known   = out_word_ff.length_known;
   assign rsp_content_length = out_word_ff.length_value;
   assign rsp_body_count     = out_word_ff.body_count;

endmodule

// ===== rtl/core/hhlf_checker.sv =====
// Port-level checker of the HTTP header length framer and its bind to the top level.
module hhlf_checker (
   input logic                             clock,
   input logic                             reset,
   input logic                             rsp_valid,
   input logic                             rsp_stall,
   input logic [2:0]                       rsp_status,
   input logic                             rsp_is_body,
   input logic                             rsp_length_known,
   input logic [hhlf_pkg::OUT_LEN_BITS-1:0] rsp_content_length,
   input logic [hhlf_pkg::OUT_LEN_BITS-1:0] rsp_body_count
);
   import hhlf_pkg::*;

   // A body byte only appears in the body phase or on the byte that completes it.
   a_body_phase: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_is_body |->
         (rsp_status == STATUS_BODY || rsp_status == STATUS_DONE_LEN))
      else $error("body byte outside the body phase");

   // A body byte needs a known length.
   a_body_len: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_is_body |-> rsp_length_known)
      else $error("body byte without a known length");

   // The length reads as zero until one is parsed.
   a_len_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_length_known |-> rsp_content_length == '0)
      else $error("content length shown before it is known");

   // Completion by length means the count reached the length.
   a_done_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == STATUS_DONE_LEN |->
         rsp_length_known && rsp_body_count == rsp_content_length)
      else $error("completed by length with a short count");

   // A stalled result word holds.
   a_hold: assert property (@(posedge clock) disable iff (reset)
      !reset && rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_status) &&
         $stable(rsp_is_body) && $stable(rsp_length_known) &&
         $stable(rsp_content_length) && $stable(rsp_body_count))
      else $error("stalled result word changed");

endmodule

bind http_header_length_framer hhlf_checker u_hhlf_checker (
   .clock              (clock),
   .reset              (reset),
   .rsp_valid          (rsp_valid),
   .rsp_stall          (rsp_stall),
   .rsp_status         (rsp_status),
   .rsp_is_body        (rsp_is_body),
   .rsp_length_known   (rsp_length_known),
   .rsp_content_length (rsp_content_length),
   .rsp_body_count     (rsp_body_count)
);
